// File: rtl/i2c_slave_register_file_macros.svh
// Assertion macros for the I2C slave register file.
// Depends on signals clk and rst_n in the including module.
`ifndef I2C_SLAVE_REGISTER_FILE_MACROS_SVH
`define I2C_SLAVE_REGISTER_FILE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define I2CSRF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2csrf assertion failed");
// next-cycle implication
`define I2CSRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2csrf assertion failed");
`else
`define I2CSRF_ASSERT_NOW(label, ante, cons)
`define I2CSRF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/i2csrf_pkg.sv
// Shared types and codes for the I2C slave register file.
// No dependencies.
`default_nettype none

package i2csrf_pkg;

  // input word: one bus event
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [2:0] line_action;
    logic [7:0] tx_byte;
    logic [2:0] bus_phase;
  } out_word_t;

  // event codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_STOP  = 2'd1;
  localparam logic [1:0] ACT_BYTE  = 2'd2;

  // bus phases
  localparam logic [2:0] PH_IDLE         = 3'd0;
  localparam logic [2:0] PH_ADDRESS      = 3'd1;
  localparam logic [2:0] PH_SEND         = 3'd2;
  localparam logic [2:0] PH_AWAIT_ACK    = 3'd3;
  localparam logic [2:0] PH_CHECK_ACK    = 3'd4;
  localparam logic [2:0] PH_REQUEST_DATA = 3'd5;
  localparam logic [2:0] PH_GET_DATA     = 3'd6;

  // line actions
  localparam logic [2:0] LA_NONE       = 3'd0;
  localparam logic [2:0] LA_WAIT_START = 3'd1;
  localparam logic [2:0] LA_DRIVE_ACK  = 3'd2;
  localparam logic [2:0] LA_RECEIVE    = 3'd3;
  localparam logic [2:0] LA_TRANSMIT   = 3'd4;
  localparam logic [2:0] LA_SAMPLE_ACK = 3'd5;

  // general call address byte
  localparam logic [7:0] GENERAL_CALL = 8'h00;

  // config port
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam logic [0:0]  REG_OWN_ADDRESS = 1'b0;

endpackage

`default_nettype wire

// File: rtl/i2csrf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module i2csrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/i2c_slave_register_file.sv
// Top level of the byte-level I2C slave register file.
// Depends on i2csrf_pkg, i2csrf_ram and i2c_slave_register_file_macros.svh.
//
//  channel | ports                         | moves
//  --------+-------------------------------+-------------------------------
//  in      | in_valid/in_ready/in_data     | one bus event word per accept
//  out     | out_valid/out_ready/out_data  | one result word per event
//  cfg     | psel/penable/pwrite/paddr/... | own_address at byte address 0
//
// One word per cycle sustained while out_ready stays high. Each accepted
// event is decoded in one pass into out_r, or the skid entry if out stalls.
// The store read is prefetched: the RAM registered read port always holds
// the entry at the pointer the next event would use.
// A result register plus one skid entry keep in_ready high while one
// result waits; in_ready drops only when both are full.
// Reset (rst_n low, synchronous) clears phase, pointer, own_address, the
// output stage valid flags and the per-entry valid bits; unwritten entries read as 0.
`default_nettype none
`include "i2c_slave_register_file_macros.svh"

module i2c_slave_register_file #(
  parameter int unsigned INDEX_BITS = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // event words
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire i2csrf_pkg::in_word_t                in_data,
  // result words
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output i2csrf_pkg::out_word_t                    out_data,
  // config
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [i2csrf_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  import i2csrf_pkg::*;

  localparam int unsigned DEPTH = 1 << INDEX_BITS;

  // ---------------- config register ----------------
  logic [6:0] own_addr_r;
  logic       cfg_wr;
  logic       cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2:2] == REG_OWN_ADDRESS);
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = cfg_hit ? {25'd0, own_addr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= 7'd0;
    end else if (cfg_wr && cfg_hit) begin
      own_addr_r <= pwdata[6:0];
    end
  end

  // ---------------- bus state ----------------
  logic [2:0]            phase_r, phase_nxt;
  logic [INDEX_BITS-1:0] ptr_r, ptr_nxt;
  logic                  unset_r, unset_nxt;
  logic [DEPTH-1:0]      valid_r, valid_nxt;
  logic                  rd_valid_r;

  logic                  in_fire;
  logic [INDEX_BITS-1:0] ptr_eff;      // pointer a read uses now
  logic [INDEX_BITS-1:0] rd_addr;      // pointer the next read will use
  logic [7:0]            ram_rdata;
  logic [7:0]            cur_byte;     // store entry at ptr_eff
  logic                  ram_we;
  logic                  addr_match;
  out_word_t             res;

  assign in_fire    = in_valid && in_ready;
  assign ptr_eff    = unset_r ? '0 : ptr_r;
  assign cur_byte   = rd_valid_r ? ram_rdata : 8'd0;
  assign addr_match = (in_data.rx_byte == GENERAL_CALL) ||
                      (in_data.rx_byte[7:1] == own_addr_r);

  // one event, one pass
  always_comb begin
    phase_nxt       = phase_r;
    ptr_nxt         = ptr_r;
    unset_nxt       = unset_r;
    ram_we          = 1'b0;
    res.line_action = LA_NONE;
    res.tx_byte     = 8'd0;
    if (in_fire) begin
      case (in_data.action)
        ACT_START: begin
          phase_nxt       = PH_ADDRESS;
          res.line_action = LA_RECEIVE;
        end
        ACT_STOP: begin
          phase_nxt = PH_IDLE;
        end
        ACT_BYTE: begin
          case (phase_r)
            PH_ADDRESS: begin
              if (addr_match) begin
                if (in_data.rx_byte[0]) begin
                  phase_nxt = PH_SEND;
                end else begin
                  phase_nxt = PH_REQUEST_DATA;
                  unset_nxt = 1'b1;
                end
                res.line_action = LA_DRIVE_ACK;
              end else begin
                phase_nxt       = PH_IDLE;
                res.line_action = LA_WAIT_START;
              end
            end
            PH_CHECK_ACK, PH_SEND: begin
              // master NACK ends the read
              if (phase_r == PH_CHECK_ACK && in_data.rx_byte != 8'd0) begin
                phase_nxt       = PH_IDLE;
                res.line_action = LA_WAIT_START;
              end else begin
                res.tx_byte     = cur_byte;
                res.line_action = LA_TRANSMIT;
                ptr_nxt         = ptr_eff + INDEX_BITS'(1);
                unset_nxt       = 1'b0;
                phase_nxt       = PH_AWAIT_ACK;
              end
            end
            PH_AWAIT_ACK: begin
              phase_nxt       = PH_CHECK_ACK;
              res.line_action = LA_SAMPLE_ACK;
            end
            PH_REQUEST_DATA: begin
              phase_nxt       = PH_GET_DATA;
              res.line_action = LA_RECEIVE;
            end
            PH_GET_DATA: begin
              // first data byte loads the pointer
              if (unset_r) begin
                ptr_nxt   = in_data.rx_byte[INDEX_BITS-1:0];
                unset_nxt = 1'b0;
              end else begin
                ram_we  = 1'b1;
                ptr_nxt = ptr_r + INDEX_BITS'(1);
              end
              phase_nxt       = PH_REQUEST_DATA;
              res.line_action = LA_DRIVE_ACK;
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    res.bus_phase = phase_nxt;
  end

  // prefetch address; never equals a write address in the same cycle
  assign rd_addr = unset_nxt ? '0 : ptr_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (ram_we) begin
      valid_nxt[ptr_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      ptr_r      <= '0;
      unset_r    <= 1'b0;
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      ptr_r      <= ptr_nxt;
      unset_r    <= unset_nxt;
      valid_r    <= valid_nxt;
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  i2csrf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (in_data.rx_byte),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // ---------------- result register + skid ----------------
  out_word_t out_r, skid_r;
  logic      out_valid_r, skid_valid_r;
  logic      out_fire;

  assign out_fire  = out_valid_r && out_ready;
  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  // ---------------- checks ----------------
  `I2CSRF_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r)
  `I2CSRF_ASSERT_NOW(a_tx_only_on_transmit,
                     out_valid_r && out_r.line_action != LA_TRANSMIT,
                     out_r.tx_byte == 8'd0)
  `I2CSRF_ASSERT_NOW(a_store_write_needs_ptr, ram_we,
                     !unset_r && phase_r == PH_GET_DATA)
  `I2CSRF_ASSERT_NEXT(a_start_to_address, in_fire && in_data.action == ACT_START,
                      phase_r == PH_ADDRESS)

endmodule

`default_nettype wire
